// ===== sv/rdf_pkg.sv =====
// Shared types and constants for the route request duplicate filter.
`timescale 1ns / 1ps

package rdf_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned ID_W   = 32;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned SLOT_W = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PEND
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              dup;
		logic              empty_found;
		logic [TIME_W-1:0] min_time;
	} stat_t;

endpackage

// ===== sv/rdf_cell.sv =====
// One cache entry of the filter plus its stage of the search record.
`timescale 1ns / 1ps

module rdf_cell #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned INDEX   = 0,
	parameter int unsigned IW      = $clog2(ENTRIES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rdf_pkg::ADDR_W-1:0] q_source,
	input  logic [rdf_pkg::ID_W-1:0]   q_id,
	input  logic                       wr_en,
	input  logic [IW-1:0]              wr_idx,
	input  logic [rdf_pkg::ADDR_W-1:0] wr_source,
	input  logic [rdf_pkg::ID_W-1:0]   wr_id,
	input  logic [rdf_pkg::TIME_W-1:0] wr_time,
	input  rdf_pkg::stat_t             stat_in,
	input  logic [IW-1:0]              dup_idx_in,
	input  logic [IW-1:0]              empty_idx_in,
	input  logic [IW-1:0]              min_idx_in,
	output rdf_pkg::stat_t             stat_out,
	output logic [IW-1:0]              dup_idx_out,
	output logic [IW-1:0]              empty_idx_out,
	output logic [IW-1:0]              min_idx_out
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic [rdf_pkg::ADDR_W-1:0] source_q;
	logic [rdf_pkg::ID_W-1:0]   id_q;
	logic [rdf_pkg::TIME_W-1:0] time_q;

	rdf_pkg::stat_t stat_d;
	rdf_pkg::stat_t stat_q;
	logic [IW-1:0]  dup_idx_d, empty_idx_d, min_idx_d;
	logic [IW-1:0]  dup_idx_q, empty_idx_q, min_idx_q;
	logic           hit, vacant, older;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= '0;
			id_q     <= '0;
			time_q   <= '0;
		end else if (wr_en && (wr_idx == MY_IDX)) begin
			source_q <= wr_source;
			id_q     <= wr_id;
			time_q   <= wr_time;
		end
	end

	always_comb begin
		hit    = !stat_in.dup && (source_q == q_source) && (id_q == q_id);
		vacant = !stat_in.empty_found && (source_q == '0);
		older  = (INDEX == 0) || (time_q < stat_in.min_time);

		stat_d             = stat_in;
		dup_idx_d          = dup_idx_in;
		empty_idx_d        = empty_idx_in;
		min_idx_d          = min_idx_in;
		if (hit) begin
			stat_d.dup = 1'b1;
			dup_idx_d  = MY_IDX;
		end
		if (vacant) begin
			stat_d.empty_found = 1'b1;
			empty_idx_d        = MY_IDX;
		end
		if (older) begin
			stat_d.min_time = time_q;
			min_idx_d       = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
		end else begin
			stat_q <= stat_d;
		end
	end

	always_ff @(posedge clk) begin
		dup_idx_q   <= dup_idx_d;
		empty_idx_q <= empty_idx_d;
		min_idx_q   <= min_idx_d;
	end

	assign stat_out      = stat_q;
	assign dup_idx_out   = dup_idx_q;
	assign empty_idx_out = empty_idx_q;
	assign min_idx_out   = min_idx_q;

endmodule

// ===== sv/rreq_duplicate_filter.sv =====
// Top level of the route request duplicate filter: control, cell chain, output word.
//
// Request channel (req_valid, req_stall) carries source_addr, broadcast_id and
// now_time; response channel (rsp_valid, rsp_stall) carries is_duplicate and
// slot_index, one response word per request word.
// A request is held in a query register and a search record walks the row of
// ENTRIES cells, one cell per cycle. At the tail the slot is chosen (lowest
// match, else lowest empty slot, else oldest time) and, unless a match was
// found, written in the same cycle. A response passes the query register, the
// ENTRIES cell registers, the result register and the output register; the
// cell row handles one request at a time.
// req_stall is high from accept until the response is loaded into the output
// register. While the receiver stalls, the response holds and a following
// request may still be accepted and searched; it then waits in a result
// register until the output register frees.
// Reset clears all entries to empty and leaves both channels idle.
`timescale 1ns / 1ps

module rreq_duplicate_filter #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [rdf_pkg::ADDR_W-1:0] source_addr,
	input  logic [rdf_pkg::ID_W-1:0]   broadcast_id,
	input  logic [rdf_pkg::TIME_W-1:0] now_time,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       is_duplicate,
	output logic [rdf_pkg::SLOT_W-1:0] slot_index
);

	localparam int unsigned IW = $clog2(ENTRIES);

	rdf_pkg::state_t state_q, state_d;

	logic [rdf_pkg::ADDR_W-1:0] q_source_q;
	logic [rdf_pkg::ID_W-1:0]   q_id_q;
	logic [rdf_pkg::TIME_W-1:0] q_time_q;
	logic                       launch_q;

	rdf_pkg::stat_t stat [0:ENTRIES];
	logic [IW-1:0]  dup_idx [0:ENTRIES];
	logic [IW-1:0]  empty_idx [0:ENTRIES];
	logic [IW-1:0]  min_idx [0:ENTRIES];
	logic [ENTRIES-1:0] tok_valid;

	rdf_pkg::stat_t tail;
	logic           accept, wr_en, load_res, load_out;
	logic [IW-1:0]  victim;
	logic           res_dup_q;
	logic [IW-1:0]  res_idx_q;
	logic           rsp_valid_q, is_dup_q;
	logic [rdf_pkg::SLOT_W-1:0] slot_q;

	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rdf_pkg::ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_source_q <= source_addr;
			q_id_q     <= broadcast_id;
			q_time_q   <= now_time;
		end
	end

	always_comb begin
		stat[0].valid       = launch_q;
		stat[0].dup         = 1'b0;
		stat[0].empty_found = 1'b0;
		stat[0].min_time    = '1;
		dup_idx[0]          = '0;
		empty_idx[0]        = '0;
		min_idx[0]          = '0;
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		rdf_cell #(
			.ENTRIES (ENTRIES),
			.INDEX   (g),
			.IW      (IW)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.q_source      (q_source_q),
			.q_id          (q_id_q),
			.wr_en         (wr_en),
			.wr_idx        (victim),
			.wr_source     (q_source_q),
			.wr_id         (q_id_q),
			.wr_time       (q_time_q),
			.stat_in       (stat[g]),
			.dup_idx_in    (dup_idx[g]),
			.empty_idx_in  (empty_idx[g]),
			.min_idx_in    (min_idx[g]),
			.stat_out      (stat[g+1]),
			.dup_idx_out   (dup_idx[g+1]),
			.empty_idx_out (empty_idx[g+1]),
			.min_idx_out   (min_idx[g+1])
		);
		assign tok_valid[g] = stat[g+1].valid;
	end

	assign tail = stat[ENTRIES];

	always_comb begin
		if (tail.dup) begin
			victim = dup_idx[ENTRIES];
		end else if (tail.empty_found) begin
			victim = empty_idx[ENTRIES];
		end else begin
			victim = min_idx[ENTRIES];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rdf_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = rdf_pkg::ST_SCAN;
				end
			end
			rdf_pkg::ST_SCAN: begin
				if (tail.valid) begin
					state_d = rdf_pkg::ST_PEND;
				end
			end
			rdf_pkg::ST_PEND: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = rdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rdf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		wr_en     = 1'b0;
		load_res  = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			rdf_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			rdf_pkg::ST_SCAN: begin
				load_res = tail.valid;
				wr_en    = tail.valid && !tail.dup;
			end
			rdf_pkg::ST_PEND: begin
				load_out = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_dup_q <= tail.dup;
			res_idx_q <= victim;
		end
		if (load_out) begin
			is_dup_q <= res_dup_q;
			slot_q   <= rdf_pkg::SLOT_W'(res_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign is_duplicate = is_dup_q;
	assign slot_index   = slot_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_valid, launch_q}))
		else $error("more than one search record in the cell row");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rdf_pkg::ST_IDLE |-> !launch_q && tok_valid == '0)
		else $error("search record alive while idle");

	a_tail_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> state_q == rdf_pkg::ST_SCAN)
		else $error("search record reached tail outside scan");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !wr_en && state_q == rdf_pkg::ST_PEND)
		else $error("entry write not followed by pending result");

endmodule

// ===== tb/rdf_checker.sv =====
// Checker for the route request duplicate filter: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module rdf_checker #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  logic [rdf_pkg::ADDR_W-1:0] source_addr,
	input  logic [rdf_pkg::ID_W-1:0]   broadcast_id,
	input  logic [rdf_pkg::TIME_W-1:0] now_time,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  logic                       is_duplicate,
	input  logic [rdf_pkg::SLOT_W-1:0] slot_index,
	output int                         fail_count,
	output int                         pending
);

	typedef struct packed {
		logic                       dup;
		logic [rdf_pkg::SLOT_W-1:0] slot;
	} verdict_t;

	logic [rdf_pkg::ADDR_W-1:0] cache_src  [ENTRIES];
	logic [rdf_pkg::ID_W-1:0]   cache_id   [ENTRIES];
	logic [rdf_pkg::TIME_W-1:0] cache_time [ENTRIES];
	verdict_t                   verdict_q  [$];
	int                         errors = 0;

	task automatic report_error(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic verdict_t filter_lookup(
		input logic [rdf_pkg::ADDR_W-1:0] src,
		input logic [rdf_pkg::ID_W-1:0]   bid,
		input logic [rdf_pkg::TIME_W-1:0] stamp
	);
		verdict_t                   v;
		int                         victim;
		logic [rdf_pkg::TIME_W-1:0] oldest;
		for (int k = 0; k < ENTRIES; k++) begin
			if (cache_src[k] == src && cache_id[k] == bid) begin
				v.dup  = 1'b1;
				v.slot = rdf_pkg::SLOT_W'(k);
				return v;
			end
		end
		victim = -1;
		for (int k = 0; k < ENTRIES; k++) begin
			if (cache_src[k] == '0) begin
				victim = k;
				break;
			end
		end
		if (victim < 0) begin
			victim = 0;
			oldest = cache_time[0];
			for (int k = 1; k < ENTRIES; k++) begin
				if (cache_time[k] < oldest) begin
					oldest = cache_time[k];
					victim = k;
				end
			end
		end
		cache_src[victim]  = src;
		cache_id[victim]   = bid;
		cache_time[victim] = stamp;
		v.dup  = 1'b0;
		v.slot = rdf_pkg::SLOT_W'(victim);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			for (int k = 0; k < ENTRIES; k++) begin
				cache_src[k]  = '0;
				cache_id[k]   = '0;
				cache_time[k] = '0;
			end
			verdict_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (verdict_q.size() == 0) begin
					report_error($sformatf("unexpected word dup=%0b slot=%0d",
						is_duplicate, slot_index));
				end else begin
					want = verdict_q.pop_front();
					if (is_duplicate !== want.dup)
						report_error($sformatf("is_duplicate got %0b want %0b",
							is_duplicate, want.dup));
					if (slot_index !== want.slot)
						report_error($sformatf("slot_index got %0d want %0d",
							slot_index, want.slot));
				end
			end
			if (req_valid && !req_stall)
				verdict_q.push_back(filter_lookup(source_addr, broadcast_id, now_time));
			fail_count <= errors;
			pending    <= verdict_q.size();
		end
	end

endmodule

// ===== tb/rreq_duplicate_filter_tb.sv =====
// Testbench top for the route request duplicate filter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module rreq_duplicate_filter_tb;

	localparam int unsigned ENTRIES      = 16;
	localparam int unsigned RANDOM_WORDS = 1620;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_LIMIT  = 5000;
	localparam int unsigned RUN_LIMIT_NS = 1600000;

	typedef struct packed {
		logic [rdf_pkg::ADDR_W-1:0] src;
		logic [rdf_pkg::ID_W-1:0]   bid;
	} pair_t;

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_stall;
	logic [rdf_pkg::ADDR_W-1:0] source_addr;
	logic [rdf_pkg::ID_W-1:0]   broadcast_id;
	logic [rdf_pkg::TIME_W-1:0] now_time;
	logic                       rsp_valid;
	logic                       rsp_stall;
	logic                       is_duplicate;
	logic [rdf_pkg::SLOT_W-1:0] slot_index;
	int                         fail_count;
	int                         pending;

	int                         burst_left;
	logic [rdf_pkg::TIME_W-1:0] wall_ms;
	pair_t                      recent_pairs [$];

	rreq_duplicate_filter #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.source_addr(source_addr),
		.broadcast_id(broadcast_id),
		.now_time(now_time),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.is_duplicate(is_duplicate),
		.slot_index(slot_index)
	);

	rdf_checker #(
		.ENTRIES(ENTRIES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.source_addr(source_addr),
		.broadcast_id(broadcast_id),
		.now_time(now_time),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.is_duplicate(is_duplicate),
		.slot_index(slot_index),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

	// offer one word, hold it until taken, then maybe idle between bursts
	task automatic send_word(
		input logic [rdf_pkg::ADDR_W-1:0] src,
		input logic [rdf_pkg::ID_W-1:0]   bid,
		input logic [rdf_pkg::TIME_W-1:0] stamp
	);
		int gap;
		source_addr  <= src;
		broadcast_id <= bid;
		now_time     <= stamp;
		req_valid    <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
				: $urandom_range(12, 1);
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(30, 1);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_random_word();
		pair_t                      p;
		logic [rdf_pkg::TIME_W-1:0] stamp;
		int                         pick;
		int                         tpick;
		bit                         known;
		pick = $urandom_range(99);
		if (pick < 35 && recent_pairs.size() > 0) begin
			p = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
		end else if (pick < 75) begin
			p.src = $urandom_range(48, 1);
			p.bid = $urandom_range(7);
		end else if (pick < 88) begin
			p.src = $urandom;
			p.bid = $urandom;
		end else if (pick < 95) begin
			p.src = '0;
			p.bid = ($urandom_range(3) == 0) ? $urandom : $urandom_range(15);
		end else begin
			p = '0;
		end
		wall_ms += $urandom_range(40);
		tpick = $urandom_range(99);
		if (tpick < 70)
			stamp = wall_ms;
		else if (tpick < 80)
			stamp = wall_ms - $urandom_range(5000);
		else if (tpick < 88)
			stamp = $urandom;
		else if (tpick < 94)
			stamp = '0;
		else
			stamp = '1;
		known = 1'b0;
		foreach (recent_pairs[i])
			if (recent_pairs[i] == p) known = 1'b1;
		if (!known) begin
			recent_pairs.push_back(p);
			if (recent_pairs.size() > 32) void'(recent_pairs.pop_front());
		end
		send_word(p.src, p.bid, stamp);
	endtask

	initial begin : stimulus
		int waited;
		req_valid    <= 1'b0;
		source_addr  <= '0;
		broadcast_id <= '0;
		now_time     <= '0;
		burst_left   = 4;
		wall_ms      = 32'd1000;
		@(posedge arst_n);
		@(posedge clk);

		// zero pair, zero source, all-ones pair and source one against an initially empty store
		send_word(32'd0, 32'd0, 32'd100);
		send_word(32'd0, 32'd5, 32'd200);
		send_word(32'd0, 32'd5, 32'd300);
		send_word(32'd0, 32'd0, 32'd10);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_word(32'd1, 32'd0, 32'd0);
		// fill the store, with tied and stale times
		for (int k = 0; k < 14; k++)
			send_word(32'(k + 2), 32'(32'h100 + k), (k % 3 == 0) ? 32'd50 : 32'(1000 + k));
		// full store: evict oldest, then a zero pair that empties its slot again
		send_word(32'h8000_0000, 32'h1234_5678, 32'h7FFF_FFFF);
		send_word(32'd0, 32'd0, 32'd2000);
		send_word(32'd0, 32'd0, 32'd2001);
		send_word(32'h8000_0000, 32'h1234_5678, 32'd5);
		send_word(32'h5555_AAAA, 32'hAAAA_5555, 32'd1);

		repeat (RANDOM_WORDS) send_random_word();
		req_valid <= 1'b0;

		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < DRAIN_LIMIT);

		if (pending != 0) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			repeat (ENTRIES + 3 + 16) @(posedge clk);
			if (fail_count == 0 && pending == 0)
				$display("Regression PASS");
			else
				$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : response_stall
		int  seg_len;
		int  stall_pct;
		int  cycles;
		bit  held;
		rsp_stall <= 1'b0;
		cycles = 0;
		held   = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			// hold off long enough for the block to back up into the sender
			if ((!held && cycles > 2000) || $urandom_range(99) < 2) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				cycles += HOLD_CYCLES;
			end
			seg_len   = $urandom_range(200, 30);
			stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(70);
			repeat (seg_len) begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
				@(posedge clk);
			end
			cycles += seg_len;
		end
	end

endmodule
